// File: rtl/core/hvt_pkg.sv
// Shared widths for the homogeneous vertex transform.
package hvt_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned ProdW  = 2 * CoordW;
  localparam int unsigned DotW   = ProdW + 2;
  localparam int unsigned QuoW   = 32;
  localparam int unsigned DivLat = QuoW + 2;
  localparam int unsigned NumCfg = 8;
  localparam int unsigned CfgW   = 64;
  localparam int unsigned CfgIdxW = 3;
endpackage

// File: rtl/core/hvt_dot.sv
// One row lane: four products, then their exact sum.
module hvt_dot
  import hvt_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [CoordW-1:0] e_i [4],
  input  logic signed [CoordW-1:0] v_i [4],
  output logic signed [DotW-1:0]   dot_o
);
  logic signed [ProdW-1:0] prod_q [4];
  logic signed [DotW-1:0]  sum_q;
  logic signed [DotW-1:0]  sum_d;

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < 4; k++) begin
      sum_d = sum_d + DotW'(prod_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        prod_q[k] <= e_i[k] * v_i[k];
      end
      sum_q <= sum_d;
    end
  end

  assign dot_o = sum_q;
endmodule

// File: rtl/core/hvt_div.sv
// Pipelined restoring divider: scaled num / den, truncated, saturated to 32 bits.
module hvt_div
  import hvt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [DotW-1:0] num_i,
  input  logic [DotW-1:0]        den_i,
  input  logic                   den_neg_i,
  output logic [QuoW-1:0]        res_o
);
  localparam int unsigned NumW = DotW + FRAC_BITS;
  localparam int unsigned CmpW = DotW + QuoW;

  logic [NumW-1:0] nmag_q;
  logic [DotW-1:0] den_a_q;
  logic            neg_a_q;
  logic [DotW-1:0] nm;

  logic [DotW-1:0] r_q   [QuoW+1];
  logic [QuoW-1:0] lo_q  [QuoW+1];
  logic [QuoW-1:0] q_q   [QuoW+1];
  logic [DotW-1:0] den_q [QuoW+1];
  logic            neg_q [QuoW+1];
  logic            ovf_q [QuoW+1];

  logic            ovf_d;
  logic [QuoW-1:0] limit;
  logic [QuoW-1:0] qsat;

  assign nm = num_i[DotW-1] ? DotW'(-num_i) : DotW'(num_i);
  assign ovf_d = CmpW'(nmag_q) >= {den_a_q, {QuoW{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nmag_q  <= {nm, {FRAC_BITS{1'b0}}};
      den_a_q <= den_i;
      neg_a_q <= num_i[DotW-1] ^ den_neg_i;
      r_q[0]   <= DotW'(nmag_q[NumW-1:QuoW]);
      lo_q[0]  <= nmag_q[QuoW-1:0];
      q_q[0]   <= '0;
      den_q[0] <= den_a_q;
      neg_q[0] <= neg_a_q;
      ovf_q[0] <= ovf_d;
    end
  end

  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    logic [DotW:0] trial;
    logic          fit;
    logic [DotW:0] diff;
    assign trial = {r_q[s], lo_q[s][QuoW-1]};
    assign fit   = trial >= {1'b0, den_q[s]};
    assign diff  = trial - {1'b0, den_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1]   <= fit ? diff[DotW-1:0] : trial[DotW-1:0];
        lo_q[s+1]  <= {lo_q[s][QuoW-2:0], 1'b0};
        q_q[s+1]   <= {q_q[s][QuoW-2:0], fit};
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        ovf_q[s+1] <= ovf_q[s];
      end
    end
  end

  assign limit = neg_q[QuoW] ? {1'b1, {(QuoW-1){1'b0}}} : {1'b0, {(QuoW-1){1'b1}}};
  assign qsat  = (ovf_q[QuoW] || q_q[QuoW] > limit) ? limit : q_q[QuoW];
  assign res_o = neg_q[QuoW] ? QuoW'(-qsat) : qsat;
endmodule

// File: rtl/core/homogeneous_vertex_transform.sv
// Top level: 4x4 matrix times vertex, then perspective divide of x, y, z by w.
// Pipeline: 37 register stages from the accepting edge to result valid (2 lane,
// 34 divider, 1 output). Throughput: one item per cycle; the whole pipeline
// advances unless the output register is full and stalled.
// Reset clears the valid pipeline and loads the identity matrix.
module homogeneous_vertex_transform
  import hvt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_wr_en_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgW-1:0]          cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] in_x_i,
  input  logic signed [CoordW-1:0] in_y_i,
  input  logic signed [CoordW-1:0] in_z_i,
  input  logic signed [CoordW-1:0] in_w_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [CoordW-1:0] out_x_o,
  output logic signed [CoordW-1:0] out_y_o,
  output logic signed [CoordW-1:0] out_z_o,
  output logic                     w_zero_o
);
  localparam int unsigned Lat = DivLat + 2;
  localparam logic [CfgW-1:0] One = CfgW'(1) << FRAC_BITS;

  logic [CfgW-1:0] m_q [NumCfg];
  logic            en;
  logic [Lat-1:0]  vld_q;
  logic [DivLat-1:0] wz_q;
  logic            out_valid_q;
  logic signed [CoordW-1:0] out_q [3];
  logic            wz_out_q;

  logic signed [CoordW-1:0] v [4];
  logic signed [DotW-1:0]   dot [4];
  logic [QuoW-1:0]          res [3];
  logic                     wzero;
  logic                     wneg;
  logic [DotW-1:0]          wmag;

  assign en = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;
  assign v[0] = in_x_i;
  assign v[1] = in_y_i;
  assign v[2] = in_z_i;
  assign v[3] = in_w_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q[0] <= One;
      m_q[1] <= '0;
      m_q[2] <= One << CoordW;
      m_q[3] <= '0;
      m_q[4] <= '0;
      m_q[5] <= One;
      m_q[6] <= '0;
      m_q[7] <= One << CoordW;
    end else if (cfg_wr_en_i) begin
      m_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_lane
    logic signed [CoordW-1:0] e [4];
    assign e[0] = m_q[2*r][CoordW-1:0];
    assign e[1] = m_q[2*r][CfgW-1:CoordW];
    assign e[2] = m_q[2*r+1][CoordW-1:0];
    assign e[3] = m_q[2*r+1][CfgW-1:CoordW];
    hvt_dot u_dot (
      .clk_i (clk_i),
      .en_i  (en),
      .e_i   (e),
      .v_i   (v),
      .dot_o (dot[r])
    );
  end

  assign wzero = dot[3] == '0;
  assign wneg  = dot[3][DotW-1];
  assign wmag  = wneg ? DotW'(-dot[3]) : DotW'(dot[3]);

  for (genvar c = 0; c < 3; c++) begin : g_div
    hvt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i     (clk_i),
      .en_i      (en),
      .num_i     (dot[c]),
      .den_i     (wmag),
      .den_neg_i (wneg),
      .res_o     (res[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[Lat-2:0], in_valid_i};
      out_valid_q <= vld_q[Lat-1];
    end
  end

  // Merge: force zero results when w' is zero.
  always_ff @(posedge clk_i) begin
    if (en) begin
      wz_q     <= {wz_q[DivLat-2:0], wzero};
      wz_out_q <= wz_q[DivLat-1];
      for (int c = 0; c < 3; c++) begin
        out_q[c] <= wz_q[DivLat-1] ? '0 : res[c];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_q[0];
  assign out_y_o     = out_q[1];
  assign out_z_o     = out_q[2];
  assign w_zero_o    = wz_out_q;
endmodule
